### rtl/length_prefixed_pipe_deframer_assert.svh
// assertion macros for the length prefixed pipe deframer
// expects clk and rst_n in the including scope, no other dependencies
`ifndef LENGTH_PREFIXED_PIPE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_PIPE_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LPPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lppd_pkg.sv
// shared types and constants of the length prefixed pipe deframer
// no dependencies
package lppd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int TLEN_W   = 4;
    localparam int STATUS_W = 3;
    localparam int HPOS_W   = 3;
    localparam int CIDX_W   = 2;

    typedef logic [STATUS_W-1:0] status_t;

    // result status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_HDR   = 3'd1;
    localparam status_t ST_NO_DELIM  = 3'd2;
    localparam status_t ST_TYPE_LEN  = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_VERSION = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TYPELEN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DELIM   = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] VERSION_RST = 8'd48;
    localparam logic [TLEN_W-1:0] TYPELEN_RST = 4'd4;
    localparam logic [BYTE_W-1:0] DELIM_RST   = 8'd124;

    // ascii digit range and count saturation
    localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0]  ASCII_NINE = 8'h39;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;

    // one result request
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] field_index;
        logic [COUNT_W-1:0] char_index;
        logic               end_of_field;
        logic               last;
        status_t            status;
        logic [COUNT_W-1:0] body_length;
    } result_t;

endpackage

### rtl/length_prefixed_pipe_deframer.sv
// top level of the length prefixed pipe deframer: header check, body counters, result register
// depends on lppd_pkg and length_prefixed_pipe_deframer_assert.svh
//
// Takes one byte per cycle and gives at most one result per byte. A header of
// version byte, delimiter, LENGTH_DIGITS decimal digits and delimiter is
// checked silently; each body byte then comes out with its field and
// character position, and the final body byte carries tlast and the message
// status. A header error or an empty body gives one result with tlast and
// restarts the header search at the next byte. Every byte is handled in the
// cycle it is accepted, so a request can enter every cycle; the only stall
// source is the single result register, and s_axis_tready follows
// m_axis_tready whenever that register holds an untaken result.
`include "length_prefixed_pipe_deframer_assert.svh"

module length_prefixed_pipe_deframer
    import lppd_pkg::*;
#(
    parameter int LENGTH_DIGITS = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]   cfg_data,
    // input bytes
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    // results
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] out_byte, [14:8] field_index, [21:15] char_index,
    // [28:22] body_length, [31:29] zero
    output logic [31:0]         m_axis_tdata,
    output logic [3:0]          m_axis_tuser,   // [0] end_of_field, [3:1] status
    output logic                m_axis_tlast
);

    // header position of the first body byte
    localparam logic [HPOS_W-1:0] HDR_BODY = HPOS_W'(3 + LENGTH_DIGITS);
    localparam logic [HPOS_W-1:0] HDR_LAST = HPOS_W'(2 + LENGTH_DIGITS);
    localparam logic [HPOS_W-1:0] HDR_VER  = HPOS_W'(0);
    localparam logic [HPOS_W-1:0] HDR_SEP  = HPOS_W'(1);

    // configuration registers
    logic [BYTE_W-1:0]  version_reg;
    logic [TLEN_W-1:0]  type_len_reg;
    logic [BYTE_W-1:0]  delim_reg;

    // frame state
    logic [HPOS_W-1:0]  hpos_reg,   hpos_next;
    logic [COUNT_W-1:0] len_reg,    len_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [COUNT_W-1:0] field_reg,  field_next;
    logic [COUNT_W-1:0] char_reg,   char_next;
    logic               tbad_reg,   tbad_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;
    logic               res_load;

    logic               in_fire;
    logic [BYTE_W-1:0]  b;
    logic               is_delim;
    logic               is_digit;
    logic [10:0]        acc;
    logic [COUNT_W-1:0] len_acc;
    logic               final_byte;
    logic               tbad_upd;

    assign b        = s_axis_tdata;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign is_delim = (b == delim_reg);
    assign is_digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);

    // length accumulation, saturating at the count limit
    assign acc     = ({4'd0, len_reg} * 11'd10) + {7'd0, b[3:0]};
    assign len_acc = (acc > {4'd0, COUNT_MAX}) ? COUNT_MAX : acc[COUNT_W-1:0];

    assign final_byte = (remain_reg <= 7'd1);
    assign tbad_upd   = tbad_reg ||
                        (is_delim && (field_reg == '0) && (char_reg != {3'd0, type_len_reg}));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg  <= VERSION_RST;
            type_len_reg <= TYPELEN_RST;
            delim_reg    <= DELIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERSION: version_reg  <= cfg_data;
                CFG_TYPELEN: type_len_reg <= cfg_data[TLEN_W-1:0];
                CFG_DELIM:   delim_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // per-byte decode and state update
    always_comb
    begin
        hpos_next   = hpos_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        field_next  = field_reg;
        char_next   = char_reg;
        tbad_next   = tbad_reg;
        res_load    = 1'b0;

        res_next              = res_reg;
        res_next.out_byte     = b;
        res_next.field_index  = '0;
        res_next.char_index   = '0;
        res_next.end_of_field = 1'b0;
        res_next.last         = 1'b1;
        res_next.status       = ST_OK;
        res_next.body_length  = len_reg;

        if (in_fire)
        begin
            if (hpos_reg < HDR_BODY)
            begin
                hpos_next = hpos_reg + HPOS_W'(1);
                priority if (hpos_reg == HDR_VER)
                begin
                    len_next             = '0;
                    res_next.body_length = '0;
                    if (b != version_reg)
                    begin
                        res_load        = 1'b1;
                        res_next.status = ST_BAD_HDR;
                        hpos_next       = HDR_VER;
                    end
                end
                else if ((hpos_reg == HDR_SEP) || (hpos_reg == HDR_LAST))
                begin
                    if (!is_delim)
                    begin
                        res_load        = 1'b1;
                        res_next.status = ST_BAD_HDR;
                        hpos_next       = HDR_VER;
                        len_next        = '0;
                    end
                    else if (hpos_reg == HDR_LAST)
                    begin
                        if (len_reg == '0)
                        begin
                            res_load        = 1'b1;
                            res_next.status = ST_EMPTY;
                            hpos_next       = HDR_VER;
                        end
                        else
                        begin
                            remain_next = len_reg;
                            field_next  = '0;
                            char_next   = '0;
                            tbad_next   = 1'b0;
                        end
                    end
                end
                else
                begin
                    // length digit
                    if (is_digit)
                    begin
                        len_next = len_acc;
                    end
                    else
                    begin
                        res_load        = 1'b1;
                        res_next.status = ST_BAD_HDR;
                        hpos_next       = HDR_VER;
                        len_next        = '0;
                    end
                end
            end
            else
            begin
                // body byte
                res_load              = 1'b1;
                res_next.field_index  = field_reg;
                res_next.char_index   = char_reg;
                res_next.end_of_field = is_delim;
                res_next.last         = final_byte;
                if (final_byte)
                begin
                    if (!is_delim)
                        res_next.status = ST_NO_DELIM;
                    else if (tbad_upd)
                        res_next.status = ST_TYPE_LEN;
                    else
                        res_next.status = ST_OK;
                    hpos_next   = HDR_VER;
                    len_next    = '0;
                    remain_next = '0;
                    field_next  = '0;
                    char_next   = '0;
                    tbad_next   = 1'b0;
                end
                else
                begin
                    remain_next = remain_reg - 7'd1;
                    tbad_next   = tbad_upd;
                    if (is_delim)
                    begin
                        field_next = (field_reg == COUNT_MAX) ? COUNT_MAX
                                                              : field_reg + 7'd1;
                        char_next  = '0;
                    end
                    else
                    begin
                        char_next = (char_reg == COUNT_MAX) ? COUNT_MAX
                                                            : char_reg + 7'd1;
                    end
                end
            end
        end
    end

    // result register handshake
    assign s_axis_tready  = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_load || (out_valid_reg && !m_axis_tready);

    // frame state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpos_reg      <= HDR_VER;
            len_reg       <= '0;
            remain_reg    <= '0;
            field_reg     <= '0;
            char_reg      <= '0;
            tbad_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hpos_reg      <= hpos_next;
            len_reg       <= len_next;
            remain_reg    <= remain_next;
            field_reg     <= field_next;
            char_reg      <= char_next;
            tbad_reg      <= tbad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_next;
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, res_reg.body_length, res_reg.char_index,
                            res_reg.field_index, res_reg.out_byte};
    assign m_axis_tuser  = {res_reg.status, res_reg.end_of_field};
    assign m_axis_tlast  = res_reg.last;

    // checks
    `LPPD_ASSERT_SAME(a_status_only_on_last, m_axis_tvalid && (m_axis_tuser[3:1] != ST_OK), m_axis_tlast, "nonzero status without last")
    `LPPD_ASSERT_SAME(a_body_has_bytes_left, hpos_reg == HDR_BODY, remain_reg != '0, "body state with no bytes remaining")
    `LPPD_ASSERT_NEXT(a_body_byte_gives_result, in_fire && (hpos_reg == HDR_BODY), m_axis_tvalid, "body byte produced no result")

endmodule
